// File: hdl/wfnm_pkg.sv
// ---------------------------------------------------------------------------
// wfnm_pkg
// Shared sizes, widths and operation codes of the weighted nearest-match unit.
// ---------------------------------------------------------------------------
package wfnm_pkg;

	localparam int MAX_FRAMES  = 4096;
	localparam int FEATURE_DIM = 26;

	localparam int FEAT_DEPTH = MAX_FRAMES * FEATURE_DIM;
	localparam int FEAT_AW    = $clog2(FEAT_DEPTH);
	localparam int FRAME_W    = $clog2(MAX_FRAMES);
	localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
	localparam int DIM_W      = (FEATURE_DIM > 1) ? $clog2(FEATURE_DIM) : 1;

	// fixed field widths
	localparam int OP_W     = 2;
	localparam int IDX_W    = 12;
	localparam int DIDX_W   = 5;
	localparam int VAL_W    = 16;
	localparam int WGT_W    = 16;
	localparam int COUNT_W  = 13;
	localparam int COST_W   = 56;
	localparam int MAG_W    = 16;
	localparam int SQ_W     = 2 * MAG_W;
	localparam int TERM_W   = SQ_W + WGT_W;

	localparam logic [COST_W-1:0] COST_MAX = '1;

	localparam logic [OP_W-1:0] OP_LOAD_DB    = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_QUERY = 2'd1;
	localparam logic [OP_W-1:0] OP_SEARCH     = 2'd2;

endpackage

// File: hdl/wfnm_in_if.sv
// ---------------------------------------------------------------------------
// wfnm_in_if
// Input item channel: load and search commands with valid/ready handshake.
// ---------------------------------------------------------------------------
interface wfnm_in_if
	import wfnm_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          operation;
	logic [IDX_W-1:0]         frame_index;
	logic [DIDX_W-1:0]        dim_index;
	logic signed [VAL_W-1:0]  value;
	logic [WGT_W-1:0]         weight;
	logic [IDX_W-1:0]         current_index;
	logic [IDX_W-1:0]         exclude_window;

	modport source (
		output valid, operation, frame_index, dim_index, value, weight,
		       current_index, exclude_window,
		input  ready
	);

	modport sink (
		input  valid, operation, frame_index, dim_index, value, weight,
		       current_index, exclude_window,
		output ready
	);
endinterface

// File: hdl/wfnm_out_if.sv
// ---------------------------------------------------------------------------
// wfnm_out_if
// Result item channel: best match of one search, valid/ready handshake.
// ---------------------------------------------------------------------------
interface wfnm_out_if
	import wfnm_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  best_index;
	logic [COST_W-1:0] best_cost;
	logic              found;

	modport source (
		output valid, best_index, best_cost, found,
		input  ready
	);

	modport sink (
		input  valid, best_index, best_cost, found,
		output ready
	);
endinterface

// File: hdl/weighted_feature_nearest_match_unit.sv
// ---------------------------------------------------------------------------
// weighted_feature_nearest_match_unit
// Weighted nearest-match search over a feature database held in block RAM.
// ---------------------------------------------------------------------------
// Load items (database or query/weight element) are accepted back to back.
// A search item scans frames 0..min(frame_count, MAX_FRAMES)-1 through the
// single port of the feature memory, one element per cycle; frames within
// the exclusion window are skipped without a memory read. The input is not
// ready while a search runs. A finished result sits in an output register,
// so loads keep flowing while it waits to be taken. Memory contents are
// undefined until loaded; there is no clearing pass after reset.
module weighted_feature_nearest_match_unit
	import wfnm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [COUNT_W-1:0] cfg_wr_data,
	wfnm_in_if.sink            in_chan,
	wfnm_out_if.source         out_chan
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]         state_q;
	logic [COUNT_W-1:0] frame_count_q;

	// storage
	logic signed [VAL_W-1:0] feat_mem [FEAT_DEPTH];
	logic signed [VAL_W-1:0] query_q  [FEATURE_DIM];
	logic [WGT_W-1:0]        weight_q [FEATURE_DIM];

	// search control
	logic [CNT_W-1:0]   fr_q;
	logic [DIM_W-1:0]   dim_q;
	logic [FEAT_AW-1:0] addr_q;
	logic [CNT_W-1:0]   cur_q;
	logic [CNT_W-1:0]   win_q;
	logic [CNT_W-1:0]   limit;
	logic [CNT_W-1:0]   fr_dist;
	logic               excluded;
	logic               issue;

	// memory port
	logic               in_acc;
	logic               db_load;
	logic               q_load;
	logic               mem_we;
	logic [FEAT_AW-1:0] load_addr;
	logic [FEAT_AW-1:0] mem_addr;

	// pipeline
	logic                    v_s1, first_s1, last_s1;
	logic [FRAME_W-1:0]      idx_s1;
	logic signed [VAL_W-1:0] feat_s1, q_s1;
	logic [WGT_W-1:0]        w_s1;
	logic signed [VAL_W:0]   diff;
	logic                    v_s2, first_s2, last_s2;
	logic [FRAME_W-1:0]      idx_s2;
	logic [MAG_W-1:0]        mag_s2;
	logic [WGT_W-1:0]        w_s2;
	logic                    v_s3, first_s3, last_s3;
	logic [FRAME_W-1:0]      idx_s3;
	logic [SQ_W-1:0]         sq_s3;
	logic [WGT_W-1:0]        w_s3;
	logic                    v_s4, first_s4, last_s4;
	logic [FRAME_W-1:0]      idx_s4;
	logic [TERM_W-1:0]       term_s4;
	logic [COST_W:0]         sum;
	logic [COST_W-1:0]       acc_q;
	logic                    fdone_s5;
	logic [FRAME_W-1:0]      idx_s5;
	logic                    pipe_busy;

	// best so far
	logic [IDX_W-1:0]  best_idx_q;
	logic [COST_W-1:0] best_cost_q;
	logic              found_q;

	// output register
	logic              out_load;
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [COST_W-1:0] out_cost_q;
	logic              out_found_q;

	assign in_chan.ready = (state_q == ST_IDLE);
	assign in_acc        = in_chan.valid && in_chan.ready;
	assign db_load       = in_acc && (in_chan.operation == OP_LOAD_DB)
	                       && (CNT_W'(in_chan.frame_index) < CNT_W'(MAX_FRAMES))
	                       && (32'(in_chan.dim_index) < 32'(FEATURE_DIM));
	assign q_load        = in_acc && (in_chan.operation == OP_LOAD_QUERY)
	                       && (32'(in_chan.dim_index) < 32'(FEATURE_DIM));
	assign mem_we        = db_load;
	assign load_addr     = FEAT_AW'(in_chan.frame_index) * FEAT_AW'(FEATURE_DIM)
	                       + FEAT_AW'(in_chan.dim_index);
	assign mem_addr      = mem_we ? load_addr : addr_q;

	assign limit    = (CNT_W'(frame_count_q) > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES)
	                  : CNT_W'(frame_count_q);
	assign fr_dist  = (fr_q > cur_q) ? (fr_q - cur_q) : (cur_q - fr_q);
	assign excluded = (win_q != '0) && (fr_dist <= win_q);
	assign issue    = (state_q == ST_SCAN) && (fr_q != limit) && !excluded;

	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4 || fdone_s5;
	assign out_load  = (state_q == ST_FINISH) && (!out_valid_q || out_chan.ready);

	// single-port feature memory: loads only in idle, reads only while scanning
	always_ff @(posedge clk) begin
		if (mem_we)
			feat_mem[mem_addr] <= in_chan.value;
		if (issue)
			feat_s1 <= feat_mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (q_load) begin
			query_q[DIM_W'(in_chan.dim_index)]  <= in_chan.value;
			weight_q[DIM_W'(in_chan.dim_index)] <= in_chan.weight;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			frame_count_q <= '0;
		else if (cfg_wr_en)
			frame_count_q <= cfg_wr_data;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fr_q        <= '0;
			dim_q       <= '0;
			addr_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_chan.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && in_chan.operation == OP_SEARCH) begin
						state_q <= ST_SCAN;
						fr_q    <= '0;
						dim_q   <= '0;
						addr_q  <= '0;
					end
				end
				ST_SCAN: begin
					if (fr_q == limit) begin
						state_q <= ST_DRAIN;
					end else if (excluded) begin
						fr_q   <= fr_q + 1'b1;
						addr_q <= addr_q + FEAT_AW'(FEATURE_DIM);
					end else begin
						addr_q <= addr_q + 1'b1;
						if (dim_q == DIM_W'(FEATURE_DIM - 1)) begin
							dim_q <= '0;
							fr_q  <= fr_q + 1'b1;
						end else begin
							dim_q <= dim_q + 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy)
						state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// pipeline valid tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			fdone_s5 <= 1'b0;
		end else begin
			v_s1     <= issue;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			fdone_s5 <= v_s4 && last_s4;
		end
	end

	assign diff = {feat_s1[VAL_W-1], feat_s1} - {q_s1[VAL_W-1], q_s1};
	assign sum  = (first_s4 ? (COST_W + 1)'(0) : {1'b0, acc_q}) + (COST_W + 1)'(term_s4);

	// datapath: read, |diff|, square, weight, saturating accumulate
	always_ff @(posedge clk) begin
		first_s1 <= (dim_q == '0);
		last_s1  <= (dim_q == DIM_W'(FEATURE_DIM - 1));
		idx_s1   <= fr_q[FRAME_W-1:0];
		q_s1     <= query_q[dim_q];
		w_s1     <= weight_q[dim_q];

		first_s2 <= first_s1;
		last_s2  <= last_s1;
		idx_s2   <= idx_s1;
		w_s2     <= w_s1;
		mag_s2   <= diff[VAL_W] ? MAG_W'(-diff) : MAG_W'(diff);

		first_s3 <= first_s2;
		last_s3  <= last_s2;
		idx_s3   <= idx_s2;
		w_s3     <= w_s2;
		sq_s3    <= SQ_W'(mag_s2) * SQ_W'(mag_s2);

		first_s4 <= first_s3;
		last_s4  <= last_s3;
		idx_s4   <= idx_s3;
		term_s4  <= TERM_W'(w_s3) * TERM_W'(sq_s3);

		if (v_s4)
			acc_q <= sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
		idx_s5 <= idx_s4;
	end

	// best-so-far; acc_q holds the frame cost while fdone_s5 is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (in_acc && in_chan.operation == OP_SEARCH) begin
			found_q <= 1'b0;
		end else if (fdone_s5 && (!found_q || acc_q < best_cost_q)) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_chan.operation == OP_SEARCH) begin
			best_idx_q  <= in_chan.current_index;
			best_cost_q <= COST_MAX;
			cur_q       <= CNT_W'(in_chan.current_index);
			win_q       <= CNT_W'(in_chan.exclude_window);
		end else if (fdone_s5 && (!found_q || acc_q < best_cost_q)) begin
			best_idx_q  <= IDX_W'(idx_s5);
			best_cost_q <= acc_q;
		end
		if (out_load) begin
			out_idx_q   <= best_idx_q;
			out_cost_q  <= best_cost_q;
			out_found_q <= found_q;
		end
	end

	assign out_chan.valid      = out_valid_q;
	assign out_chan.best_index = out_idx_q;
	assign out_chan.best_cost  = out_cost_q;
	assign out_chan.found      = out_found_q;

endmodule

// File: tb/weighted_feature_nearest_match_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// weighted_feature_nearest_match_unit_tb
// Self-checking bench for the weighted nearest-match unit. It loads feature
// and query tables, runs searches with and without exclusion windows over
// several frame counts, and checks each result against an in-bench model,
// with random idle cycles on both channels and a long output stall.
// ---------------------------------------------------------------------------
module weighted_feature_nearest_match_unit_tb;
	import wfnm_pkg::*;

	localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
	localparam int STALL_LIMIT   = 40000;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 1500;
	localparam int PREFIX_CAP    = 40;

	typedef struct packed {
		logic [OP_W-1:0]         op;
		logic [IDX_W-1:0]        frame;
		logic [DIDX_W-1:0]       dim;
		logic signed [VAL_W-1:0] value;
		logic [WGT_W-1:0]        weight;
		logic [IDX_W-1:0]        center;
		logic [IDX_W-1:0]        window;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0]  index;
		logic [COST_W-1:0] cost;
		logic              found;
	} match_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [COUNT_W-1:0] cfg_wr_data;

	wfnm_in_if  in_chan ();
	wfnm_out_if out_chan ();

	weighted_feature_nearest_match_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_chan     (in_chan),
		.out_chan    (out_chan)
	);

	// model copy of the tables and the frame count
	logic signed [VAL_W-1:0] feat_mem [FEAT_DEPTH];
	logic signed [VAL_W-1:0] query_mem [FEATURE_DIM];
	logic [WGT_W-1:0]        weight_mem [FEATURE_DIM];
	bit [FEATURE_DIM-1:0]    feat_seen [MAX_FRAMES];
	bit [FEATURE_DIM-1:0]    query_seen;
	logic [COUNT_W-1:0]      frame_count_cfg;
	match_t                  pending_matches [$];

	int mismatches;
	int results_seen;
	bit no_idle;
	int hold_requests;

	always #2 clk = ~clk;

	function automatic int search_limit();
		return (frame_count_cfg > MAX_FRAMES) ? MAX_FRAMES : int'(frame_count_cfg);
	endfunction

	function automatic bit in_window(int i, int center, int window);
		int gap;
		gap = (i > center) ? i - center : center - i;
		return (window != 0) && (gap <= window);
	endfunction

	function automatic logic [COST_W-1:0] frame_cost(int f);
		longint unsigned sum, mag, term;
		longint diff;
		sum = 0;
		for (int d = 0; d < FEATURE_DIM; d++) begin
			diff = longint'(feat_mem[f * FEATURE_DIM + d]) - longint'(query_mem[d]);
			mag  = (diff < 0) ? -diff : diff;
			term = longint'(weight_mem[d]) * mag * mag;
			sum += term;
			if (sum > COST_MAX)
				sum = COST_MAX;
		end
		return COST_W'(sum);
	endfunction

	// update tables, or work out the best match of a search
	function automatic void model_item(cmd_t c);
		match_t m;
		logic [COST_W-1:0] frame_c;
		case (c.op)
			OP_LOAD_DB: begin
				if (c.dim < FEATURE_DIM) begin
					feat_mem[int'(c.frame) * FEATURE_DIM + int'(c.dim)] = c.value;
					feat_seen[c.frame][c.dim] = 1'b1;
				end
			end
			OP_LOAD_QUERY: begin
				if (c.dim < FEATURE_DIM) begin
					query_mem[c.dim]  = c.value;
					weight_mem[c.dim] = c.weight;
					query_seen[c.dim] = 1'b1;
				end
			end
			OP_SEARCH: begin
				m = '{index: c.center, cost: COST_MAX, found: 1'b0};
				for (int i = 0; i < search_limit(); i++) begin
					if (in_window(i, c.center, c.window))
						continue;
					frame_c = frame_cost(i);
					if (!m.found || frame_c < m.cost)
						m = '{index: IDX_W'(i), cost: frame_c, found: 1'b1};
				end
				pending_matches.push_back(m);
			end
			default: ;
		endcase
	endfunction

	function automatic int full_prefix();
		int n;
		n = 0;
		while (n < MAX_FRAMES && (&feat_seen[n]))
			n++;
		return n;
	endfunction

	// a search must never examine a table entry that was never loaded
	function automatic bit search_safe(int center, int window);
		for (int i = 0; i < search_limit(); i++)
			if (!in_window(i, center, window) && !((&query_seen) && (&feat_seen[i])))
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return '0;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic logic [WGT_W-1:0] pick_weight();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return 16'h0100;
			default: return WGT_W'($urandom);
		endcase
	endfunction

	function automatic cmd_t noise_cmd();
		cmd_t c;
		c.op     = OP_W'($urandom);
		c.frame  = IDX_W'($urandom);
		c.dim    = DIDX_W'($urandom);
		c.value  = VAL_W'($urandom);
		c.weight = WGT_W'($urandom);
		c.center = IDX_W'($urandom);
		c.window = IDX_W'($urandom);
		return c;
	endfunction

	function automatic cmd_t make_search();
		cmd_t c;
		c = noise_cmd();
		c.op = OP_SEARCH;
		for (int tries = 0; tries < 8; tries++) begin
			if ($urandom_range(1))
				c.center = IDX_W'($urandom);
			else
				c.center = IDX_W'($urandom_range(search_limit() + 4));
			case ($urandom_range(2))
				0: c.window = '0;
				1: c.window = IDX_W'($urandom_range(8, 1));
				default: c.window = IDX_W'($urandom);
			endcase
			if (search_safe(c.center, c.window))
				return c;
		end
		// window from the last frame down to the first not fully loaded one (all frames if the query is incomplete)
		c.center = '1;
		c.window = (&query_seen) ? IDX_W'(MAX_FRAMES - 1 - full_prefix()) : '1;
		return c;
	endfunction

	function automatic cmd_t traffic_item();
		cmd_t c;
		int pfx, pick, d;
		c    = noise_cmd();
		pfx  = full_prefix();
		pick = $urandom_range(99);
		if (pick < 58) begin
			c.op    = OP_LOAD_DB;
			c.value = pick_value();
			if (pick < 40 || (pick >= 50 && pfx >= PREFIX_CAP)) begin
				c.frame = IDX_W'($urandom_range(pfx + 1));
				c.dim   = DIDX_W'($urandom_range(FEATURE_DIM - 1));
			end else if (pick >= 50) begin
				// grow the fully loaded prefix by one element
				d = 0;
				while (feat_seen[pfx][d])
					d++;
				c.frame = IDX_W'(pfx);
				c.dim   = DIDX_W'(d);
			end
		end else if (pick < 70) begin
			c.op     = OP_LOAD_QUERY;
			c.value  = pick_value();
			c.weight = pick_weight();
			if (pick < 68)
				c.dim = DIDX_W'($urandom_range(FEATURE_DIM - 1));
		end else if (pick < 95) begin
			c = make_search();
		end else begin
			c.op = OP_RESERVED;
		end
		return c;
	endfunction

	task automatic send_item(cmd_t c);
		while (!no_idle && $urandom_range(99) < 21) begin
			in_chan.valid <= 1'b0;
			@(negedge clk);
		end
		in_chan.valid          <= 1'b1;
		in_chan.operation      <= c.op;
		in_chan.frame_index    <= c.frame;
		in_chan.dim_index      <= c.dim;
		in_chan.value          <= c.value;
		in_chan.weight         <= c.weight;
		in_chan.current_index  <= c.center;
		in_chan.exclude_window <= c.window;
		do @(posedge clk); while (in_chan.ready !== 1'b1);
		model_item(c);
		@(negedge clk);
	endtask

	task automatic send_search(int center, int window);
		cmd_t c;
		c        = noise_cmd();
		c.op     = OP_SEARCH;
		c.center = IDX_W'(center);
		c.window = IDX_W'(window);
		send_item(c);
	endtask

	task automatic wait_drained();
		in_chan.valid <= 1'b0;
		do @(negedge clk); while (pending_matches.size() != 0);
	endtask

	task automatic set_frame_count(logic [COUNT_W-1:0] count);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= count;
		@(negedge clk);
		cfg_wr_en       <= 1'b0;
		frame_count_cfg = count;
	endtask

	// frame count is zero out of reset: nothing can be examined
	task automatic test_empty_table();
		cmd_t c;
		send_search(MAX_FRAMES - 1, 0);
		send_search(0, MAX_FRAMES - 1);
		c = '1;
		send_item(c);
		c.op = OP_LOAD_DB;
		send_item(c);
		c.op  = OP_LOAD_QUERY;
		c.dim = DIDX_W'(FEATURE_DIM);
		send_item(c);
		send_search(0, 0);
	endtask

	// query far from frame 0, equal to frames 1 and 2, random frames after
	task automatic test_fill_tables();
		cmd_t c;
		for (int d = 0; d < FEATURE_DIM; d++) begin
			c        = noise_cmd();
			c.op     = OP_LOAD_QUERY;
			c.dim    = DIDX_W'(d);
			c.value  = 16'sh8000;
			c.weight = '1;
			send_item(c);
		end
		for (int f = 0; f < 10; f++)
			for (int d = 0; d < FEATURE_DIM; d++) begin
				c       = noise_cmd();
				c.op    = OP_LOAD_DB;
				c.frame = IDX_W'(f);
				c.dim   = DIDX_W'(d);
				c.value = (f == 0) ? 16'sh7fff : (f < 3) ? 16'sh8000 : pick_value();
				send_item(c);
			end
	endtask

	task automatic test_cost_extremes();
		set_frame_count(1);
		send_search(0, 0);
		set_frame_count(3);
		send_search(0, 0);
		send_search(1, 1);
		send_search(0, 1);
		send_search(2, 1);
		set_frame_count(MAX_FRAMES);
		send_search(MAX_FRAMES - 1, MAX_FRAMES - 11);
		send_search(0, MAX_FRAMES - 1);
		set_frame_count('1);
		send_search(MAX_FRAMES - 1, MAX_FRAMES - 10);
		send_search(MAX_FRAMES - 1, MAX_FRAMES - 1);
	endtask

	task automatic test_random_traffic();
		logic [COUNT_W-1:0] count;
		for (int phase = 0; phase < 8; phase++) begin
			case ($urandom_range(9))
				0: count = '0;
				1: count = COUNT_W'(MAX_FRAMES);
				2: count = '1;
				3: count = COUNT_W'($urandom);
				default: count = COUNT_W'($urandom_range(full_prefix(), 1));
			endcase
			set_frame_count(count);
			repeat (110) send_item(traffic_item());
		end
	endtask

	// output held off while searches keep coming: the unit must stall its input
	task automatic test_output_stall();
		set_frame_count(COUNT_W'($urandom_range(6, 2)));
		hold_requests++;
		repeat (10) begin
			send_item(make_search());
			send_item(traffic_item());
		end
		wait_drained();
	endtask

	task automatic test_back_to_back();
		no_idle = 1'b1;
		set_frame_count(COUNT_W'($urandom_range(full_prefix(), 1)));
		repeat (100) send_item(traffic_item());
		wait_drained();
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n                 = 1'b0;
		cfg_wr_en              = 1'b0;
		cfg_wr_data            = '0;
		frame_count_cfg        = '0;
		in_chan.valid          = 1'b0;
		in_chan.operation      = OP_LOAD_DB;
		in_chan.frame_index    = '0;
		in_chan.dim_index      = '0;
		in_chan.value          = '0;
		in_chan.weight         = '0;
		in_chan.current_index  = '0;
		in_chan.exclude_window = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_empty_table();
		test_fill_tables();
		test_cost_extremes();
		test_output_stall();
		test_random_traffic();
		test_back_to_back();
		test_output_stall();
		wait_drained();
		repeat (40) @(negedge clk);
		if (mismatches == 0 && pending_matches.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin : result_sink
		int hold_left, hold_served;
		hold_left      = 0;
		hold_served    = 0;
		out_chan.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_chan.ready <= 1'b0;
			end else begin
				out_chan.ready <= no_idle || ($urandom_range(99) >= 21);
			end
		end
	end

	always @(posedge clk) begin : result_check
		match_t want;
		if (arst_n && out_chan.valid === 1'b1 && out_chan.ready) begin
			results_seen++;
			if (pending_matches.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d with no search pending: index %0d cost %0h found %0b",
						results_seen, out_chan.best_index, out_chan.best_cost, out_chan.found);
			end else begin
				want = pending_matches.pop_front();
				if (out_chan.best_index !== want.index || out_chan.best_cost !== want.cost ||
						out_chan.found !== want.found) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result %0d: expected index %0d cost %0h found %0b, ",
							"got index %0d cost %0h found %0b"},
							results_seen, want.index, want.cost, want.found,
							out_chan.best_index, out_chan.best_cost, out_chan.found);
				end
			end
		end
	end

	// ends the run if no item moves on either channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

endmodule

// File: sim.f
hdl/wfnm_pkg.sv
hdl/wfnm_in_if.sv
hdl/wfnm_out_if.sv
hdl/weighted_feature_nearest_match_unit.sv
tb/weighted_feature_nearest_match_unit_tb.sv
